>>> src/uih_pkg.sv
// Shared types, constants and helpers of the universal integer hash.
`timescale 1ns / 1ps

package uih_pkg;

	// Generator and register reset constants.
	localparam logic [31:0] LCG_MUL       = 32'd1664525;
	localparam logic [31:0] LCG_INC       = 32'd1013904223;
	localparam logic [30:0] PRIME_RESET   = 31'd10007;
	localparam logic [30:0] BUCKETS_RESET = 31'd16;

	// Item kinds carried in tuser.
	localparam logic [1:0] KIND_HASH   = 2'd0;
	localparam logic [1:0] KIND_REGEN  = 2'd1;
	localparam logic [1:0] KIND_RESEED = 2'd2;

	// Configuration register indexes.
	localparam logic REG_PRIME   = 1'b0;
	localparam logic REG_BUCKETS = 1'b1;

	// Step counts of the serial remainder unit.
	localparam logic [6:0] STEPS_WIDE   = 7'd64;
	localparam logic [6:0] STEPS_DRAW   = 7'd32;
	localparam logic [6:0] STEPS_BUCKET = 7'd31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_LIN,
		ST_ABS,
		ST_WAIT_P,
		ST_FIX,
		ST_WAIT_M,
		ST_START_A,
		ST_WAIT_A,
		ST_START_B,
		ST_WAIT_B,
		ST_FINISH
	} state_t;

	// Request to the serial remainder unit; the dividend is left-aligned.
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [6:0]  steps;
		logic [30:0] divisor;
	} rem_req_t;

	// One step of the linear congruential generator, modulo 2^32.
	function automatic logic [31:0] lcg_next(input logic [31:0] x);
		return x * LCG_MUL + LCG_INC;
	endfunction

endpackage

>>> src/uih_serial_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module uih_serial_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  uih_pkg::rem_req_t req,
	output logic              done,
	output logic [30:0]       rem
);

	logic [63:0] sh_q;
	logic [30:0] rem_q;
	logic [30:0] divisor_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] trial;
	logic [31:0] diff;
	logic        fits;

	// Bring down the next dividend bit and subtract the divisor when it fits.
	assign trial = {rem_q, sh_q[63]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q      <= req.dividend;
			rem_q     <= 31'd0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			sh_q  <= {sh_q[62:0], 1'b0};
			rem_q <= fits ? diff[30:0] : trial[30:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> src/universal_integer_hash.sv
// Top level of the universal integer hash: control, serial multiplier and coefficients.
`timescale 1ns / 1ps
// A hash word runs 32 multiply steps, 64 remainder steps mod p and 31 remainder steps mod m,
// with control states between them, before its result is valid; a regenerate or reseed
// word runs two 32-step remainders, and an unused kind goes straight to the result.
// One word is processed at a time; the next is accepted in the cycle after the result is
// loaded, later only while an unread result holds the output.
// Reset: arst_n clears control and restores p = 10007, m = 16, a = 1, b = 0, state 0.

module universal_integer_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key [31:0] (signed), seed_value [63:32]
	input  logic [1:0]  s_tuser,   // kind [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // bucket [30:0], coef_a [61:31], coef_b [92:62], zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);

	uih_pkg::state_t   state_q;
	uih_pkg::state_t   state_d;
	uih_pkg::rem_req_t rem_req;

	// Configuration and coefficient state.
	logic [30:0] prime_q;
	logic [30:0] buckets_q;
	logic [31:0] gen_q;
	logic [30:0] mult_q;
	logic [30:0] offset_q;

	// Working registers of one hash.
	logic [63:0] prod_q;
	logic [4:0]  cnt_q;
	logic        key_neg_q;
	logic        lin_neg_q;
	logic [30:0] bucket_q;

	// Output register.
	logic        m_valid_q;
	logic [92:0] out_q;

	logic        rem_done;
	logic [30:0] rem_val;
	logic        accept;
	logic        load_out;
	logic [30:0] p_eff;
	logic [30:0] m_eff;
	logic [31:0] key_mag;
	logic [32:0] mul_sum;
	logic [63:0] lin_mag;
	logic [30:0] r_fixed;
	logic [31:0] gen_seed;

	// A prime below two counts as two, and zero buckets as one.
	assign p_eff = (prime_q < 31'd2) ? 31'd2 : prime_q;
	assign m_eff = (buckets_q == 31'd0) ? 31'd1 : buckets_q;

	assign accept  = s_tvalid && s_tready;
	assign key_mag = s_tdata[31] ? (~s_tdata[31:0] + 32'd1) : s_tdata[31:0];

	// Shift-and-add step: add a to the upper half when the low multiplier bit is set.
	assign mul_sum = {1'b0, prod_q[63:32]} + (prod_q[0] ? {2'b00, mult_q} : 33'd0);

	// Magnitude of the signed linear term held in prod_q after the LIN step.
	assign lin_mag = prod_q[63] ? (~prod_q + 64'd1) : prod_q;

	// Mathematical remainder: a negative term with a nonzero remainder folds to p - r.
	assign r_fixed = (lin_neg_q && (rem_val != 31'd0)) ? (p_eff - rem_val) : rem_val;

	// A reseed loads the generator before the first draw.
	assign gen_seed = (s_tuser == uih_pkg::KIND_RESEED) ? s_tdata[63:32] : gen_q;

	uih_serial_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.done   (rem_done),
		.rem    (rem_val)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			uih_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						uih_pkg::KIND_HASH:   state_d = uih_pkg::ST_MUL;
						uih_pkg::KIND_REGEN:  state_d = uih_pkg::ST_START_A;
						uih_pkg::KIND_RESEED: state_d = uih_pkg::ST_START_A;
						default:              state_d = uih_pkg::ST_FINISH;
					endcase
				end
			end
			uih_pkg::ST_MUL: begin
				if (cnt_q == 5'd31) state_d = uih_pkg::ST_LIN;
			end
			uih_pkg::ST_LIN:     state_d = uih_pkg::ST_ABS;
			uih_pkg::ST_ABS:     state_d = uih_pkg::ST_WAIT_P;
			uih_pkg::ST_WAIT_P: begin
				if (rem_done) state_d = uih_pkg::ST_FIX;
			end
			uih_pkg::ST_FIX:     state_d = uih_pkg::ST_WAIT_M;
			uih_pkg::ST_WAIT_M: begin
				if (rem_done) state_d = uih_pkg::ST_FINISH;
			end
			uih_pkg::ST_START_A: state_d = uih_pkg::ST_WAIT_A;
			uih_pkg::ST_WAIT_A: begin
				if (rem_done) state_d = uih_pkg::ST_START_B;
			end
			uih_pkg::ST_START_B: state_d = uih_pkg::ST_WAIT_B;
			uih_pkg::ST_WAIT_B: begin
				if (rem_done) state_d = uih_pkg::ST_FINISH;
			end
			uih_pkg::ST_FINISH: begin
				if (!m_valid_q || m_tready) state_d = uih_pkg::ST_IDLE;
			end
			default:             state_d = uih_pkg::ST_IDLE;
		endcase
	end

	// Output logic: handshake, remainder requests and result loading.
	always_comb begin
		s_tready         = 1'b0;
		load_out         = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = lin_mag;
		rem_req.steps    = uih_pkg::STEPS_WIDE;
		rem_req.divisor  = p_eff;
		unique case (state_q)
			uih_pkg::ST_IDLE:    s_tready = 1'b1;
			uih_pkg::ST_ABS:     rem_req.start = 1'b1;
			uih_pkg::ST_FIX: begin
				rem_req.start    = 1'b1;
				rem_req.dividend = {r_fixed, 33'd0};
				rem_req.steps    = uih_pkg::STEPS_BUCKET;
				rem_req.divisor  = m_eff;
			end
			uih_pkg::ST_START_A: begin
				rem_req.start    = 1'b1;
				rem_req.dividend = {gen_q, 32'd0};
				rem_req.steps    = uih_pkg::STEPS_DRAW;
				rem_req.divisor  = p_eff - 31'd1;
			end
			uih_pkg::ST_START_B: begin
				rem_req.start    = 1'b1;
				rem_req.dividend = {gen_q, 32'd0};
				rem_req.steps    = uih_pkg::STEPS_DRAW;
			end
			uih_pkg::ST_FINISH:  load_out = !m_valid_q || m_tready;
			default: begin
			end
		endcase
	end

	// Control state, configuration and coefficients.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= uih_pkg::ST_IDLE;
			m_valid_q <= 1'b0;
			prime_q   <= uih_pkg::PRIME_RESET;
			buckets_q <= uih_pkg::BUCKETS_RESET;
			gen_q     <= 32'd0;
			mult_q    <= 31'd1;
			offset_q  <= 31'd0;
			cnt_q     <= 5'd0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					uih_pkg::REG_PRIME:   prime_q   <= cfg_data;
					uih_pkg::REG_BUCKETS: buckets_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// The first draw is taken as the word is accepted.
			if (accept && ((s_tuser == uih_pkg::KIND_REGEN) ||
					(s_tuser == uih_pkg::KIND_RESEED))) begin
				gen_q <= uih_pkg::lcg_next(gen_seed);
			end

			// The multiplier comes from the first draw; then the second draw is taken.
			if ((state_q == uih_pkg::ST_WAIT_A) && rem_done) begin
				mult_q <= rem_val + 31'd1;
				gen_q  <= uih_pkg::lcg_next(gen_q);
			end
			if ((state_q == uih_pkg::ST_WAIT_B) && rem_done) begin
				offset_q <= rem_val;
			end

			if (accept) begin
				cnt_q <= 5'd0;
			end else if (state_q == uih_pkg::ST_MUL) begin
				cnt_q <= cnt_q + 5'd1;
			end

			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the hash.
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_q    <= {32'd0, key_mag};
			key_neg_q <= s_tdata[31];
			bucket_q  <= 31'd0;
		end else begin
			unique case (state_q)
				uih_pkg::ST_MUL: prod_q <= {mul_sum, prod_q[31:1]};
				// Signed linear term: a*|key| + b, or b - a*|key| for a negative key.
				uih_pkg::ST_LIN: prod_q <= key_neg_q ? ({33'd0, offset_q} - prod_q)
				                                     : (prod_q + {33'd0, offset_q});
				uih_pkg::ST_ABS: lin_neg_q <= prod_q[63];
				uih_pkg::ST_WAIT_M: begin
					if (rem_done) bucket_q <= rem_val;
				end
				default: begin
				end
			endcase
		end

		if (load_out) begin
			out_q <= {offset_q, mult_q, bucket_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, out_q};

endmodule
